// ===== src/gfs_pkg.sv =====
// Shared types and constants for the gamepad frame sanitizer.
// Holds frame layout positions, mode codes, register indexes and result records.
// Used by gfs_frame_eval and gamepad_frame_sanitizer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gfs_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int POS_W       = 4;

    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(0);
    localparam logic [POS_W-1:0] POS_MODE  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_B3    = POS_W'(3);
    localparam logic [POS_W-1:0] POS_B4    = POS_W'(4);
    localparam logic [POS_W-1:0] POS_B5    = POS_W'(5);
    localparam logic [POS_W-1:0] POS_B6    = POS_W'(6);
    localparam logic [POS_W-1:0] POS_B7    = POS_W'(7);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0] MODE_DIGITAL_WIRED    = 8'h41;
    localparam logic [7:0] MODE_DIGITAL_WIRELESS = 8'h20;
    localparam logic [7:0] MODE_FAULT            = 8'hFF;

    localparam logic [3:0] COUNT_MAX = 4'd15;

    localparam logic [1:0] REG_TIMEOUT_LIMIT     = 2'd0;
    localparam logic [1:0] REG_LEFT_TRIGGER_BIT  = 2'd1;
    localparam logic [1:0] REG_RIGHT_TRIGGER_BIT = 2'd2;

    localparam logic [3:0] TIMEOUT_LIMIT_RESET     = 4'd10;
    localparam logic [3:0] LEFT_TRIGGER_BIT_RESET  = 4'd8;
    localparam logic [3:0] RIGHT_TRIGGER_BIT_RESET = 4'd9;

    typedef struct packed {
        logic [3:0] timeout_limit;
        logic [3:0] left_trigger_bit;
        logic [3:0] right_trigger_bit;
    } t_cfg;

    // Frame bytes 3 to 8: the only bytes mapped onto the data outputs.
    typedef struct packed {
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [7:0] b7;
        logic [7:0] b8;
    } t_tail;

    localparam t_tail DEFAULT_TAIL = '{
        b3: 8'hFF, b4: 8'hFF, b5: 8'h80, b6: 8'h80, b7: 8'h80, b8: 8'h80
    };

    typedef struct packed {
        logic [15:0] buttons;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic        reinit_request;
        logic        frame_replaced;
        logic        link_lost;
    } t_result;

endpackage

`default_nettype wire

// ===== src/gamepad_frame_sanitizer.sv =====
// Top level of the gamepad frame sanitizer: byte collection, state and result register.
// Instantiates gfs_frame_eval and uses gfs_pkg.
//
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_rx_byte, i_frame_start
// result    out        o_valid / i_stall  o_buttons .. o_link_lost
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// A byte per cycle unless stalled; a result is valid in the cycle after the ninth byte.
// The frame check is a single pass of logic between the byte registers and the result register.
// Synchronous active-low reset restores config, position, count, valid and stored frame.
// A waiting result held by the sink stalls any byte offered once eight bytes are collected.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_frame_sanitizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_start,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_buttons,
    output logic [7:0]       o_left_x,
    output logic [7:0]       o_left_y,
    output logic [7:0]       o_right_x,
    output logic [7:0]       o_right_y,
    output logic [7:0]       o_left_trigger,
    output logic [7:0]       o_right_trigger,
    output logic             o_reinit_request,
    output logic             o_frame_replaced,
    output logic             o_link_lost,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);

    gfs_pkg::t_cfg               r_cfg;
    logic [gfs_pkg::POS_W-1:0]   r_pos;
    logic                        r_nonzero;
    logic [7:0]                  r_mode;
    logic [7:0]                  r_b3, r_b4, r_b5, r_b6, r_b7;
    gfs_pkg::t_tail              r_prev;
    logic [3:0]                  r_count;
    logic                        r_out_valid;
    gfs_pkg::t_result            r_result;

    logic                        in_xfer;
    logic                        complete;
    logic [gfs_pkg::POS_W-1:0]   pos_eff;
    logic                        all_zero;
    gfs_pkg::t_tail              tail_now;
    gfs_pkg::t_result            n_result;
    gfs_pkg::t_tail              n_prev;
    logic [3:0]                  n_count;

    assign o_stall  = r_out_valid && i_stall && (r_pos == gfs_pkg::POS_LAST);
    assign in_xfer  = i_valid && !o_stall;
    assign pos_eff  = i_frame_start ? gfs_pkg::POS_FIRST : r_pos;
    assign complete = in_xfer && (pos_eff == gfs_pkg::POS_LAST);
    assign all_zero = !r_nonzero && (i_rx_byte == 8'd0);
    assign tail_now = '{b3: r_b3, b4: r_b4, b5: r_b5, b6: r_b6, b7: r_b7, b8: i_rx_byte};

    gfs_frame_eval u_eval (
        .i_tail     (tail_now),
        .i_prev     (r_prev),
        .i_mode     (r_mode),
        .i_all_zero (all_zero),
        .i_count    (r_count),
        .i_cfg      (r_cfg),
        .o_result   (n_result),
        .o_prev     (n_prev),
        .o_count    (n_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_limit     <= gfs_pkg::TIMEOUT_LIMIT_RESET;
            r_cfg.left_trigger_bit  <= gfs_pkg::LEFT_TRIGGER_BIT_RESET;
            r_cfg.right_trigger_bit <= gfs_pkg::RIGHT_TRIGGER_BIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gfs_pkg::REG_TIMEOUT_LIMIT:     r_cfg.timeout_limit     <= i_cfg_data;
                gfs_pkg::REG_LEFT_TRIGGER_BIT:  r_cfg.left_trigger_bit  <= i_cfg_data;
                gfs_pkg::REG_RIGHT_TRIGGER_BIT: r_cfg.right_trigger_bit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= gfs_pkg::POS_FIRST;
            r_nonzero <= 1'b0;
            r_prev    <= gfs_pkg::DEFAULT_TAIL;
            r_count   <= 4'd0;
        end else if (in_xfer) begin
            if (complete) begin
                r_pos   <= gfs_pkg::POS_FIRST;
                r_prev  <= n_prev;
                r_count <= n_count;
            end else begin
                r_pos <= pos_eff + gfs_pkg::POS_W'(1);
            end
            r_nonzero <= ((pos_eff != gfs_pkg::POS_FIRST) && r_nonzero) || (i_rx_byte != 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            case (pos_eff)
                gfs_pkg::POS_MODE: r_mode <= i_rx_byte;
                gfs_pkg::POS_B3:   r_b3   <= i_rx_byte;
                gfs_pkg::POS_B4:   r_b4   <= i_rx_byte;
                gfs_pkg::POS_B5:   r_b5   <= i_rx_byte;
                gfs_pkg::POS_B6:   r_b6   <= i_rx_byte;
                gfs_pkg::POS_B7:   r_b7   <= i_rx_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (complete) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (complete) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_buttons        = r_result.buttons;
    assign o_left_x         = r_result.left_x;
    assign o_left_y         = r_result.left_y;
    assign o_right_x        = r_result.right_x;
    assign o_right_y        = r_result.right_y;
    assign o_left_trigger   = r_result.left_trigger;
    assign o_right_trigger  = r_result.right_trigger;
    assign o_reinit_request = r_result.reinit_request;
    assign o_frame_replaced = r_result.frame_replaced;
    assign o_link_lost      = r_result.link_lost;

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= gfs_pkg::POS_LAST)
        else $error("byte position left the frame");

    a_good_frame_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        complete && !all_zero |=> r_count == 4'd0)
        else $error("empty count not cleared by a good frame");

    a_lost_implies_replaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_link_lost |-> o_frame_replaced)
        else $error("link lost reported without replacement");

    a_reinit_not_replaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reinit_request |-> !o_frame_replaced)
        else $error("substituted frame treated as empty");
`endif

endmodule

`default_nettype wire

// ===== src/gfs_frame_eval.sv =====
// Frame check for one completed frame: mode test, empty handling and output mapping.
// Purely combinational; the caller registers the result and the updated state.
// Depends on gfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfs_frame_eval (
    input  wire gfs_pkg::t_tail   i_tail,
    input  wire gfs_pkg::t_tail   i_prev,
    input  wire logic [7:0]       i_mode,
    input  wire logic             i_all_zero,
    input  wire logic [3:0]       i_count,
    input  wire gfs_pkg::t_cfg    i_cfg,
    output gfs_pkg::t_result      o_result,
    output gfs_pkg::t_tail        o_prev,
    output logic [3:0]            o_count
);

    logic           reinit;
    logic           empty;
    logic           lost;
    logic [3:0]     count_inc;
    gfs_pkg::t_tail f;
    logic [15:0]    keys;

    always_comb begin
        reinit = (i_mode == gfs_pkg::MODE_DIGITAL_WIRED)
              || (i_mode == gfs_pkg::MODE_DIGITAL_WIRELESS)
              || (i_mode == gfs_pkg::MODE_FAULT);
        // A substituted frame carries a nonzero mode byte and is never empty.
        empty     = i_all_zero;
        count_inc = (i_count != gfs_pkg::COUNT_MAX) ? i_count + 4'd1 : i_count;
        lost      = empty && (count_inc > i_cfg.timeout_limit);

        if (!empty) begin
            o_count = 4'd0;
        end else if (lost) begin
            o_count = i_cfg.timeout_limit + 4'd1;
        end else begin
            o_count = count_inc;
        end

        if (reinit) begin
            f = gfs_pkg::DEFAULT_TAIL;
        end else if (empty) begin
            f = lost ? gfs_pkg::DEFAULT_TAIL : i_prev;
        end else begin
            f = i_tail;
        end
        o_prev = f;

        keys = ~{f.b4, f.b3};
        o_result.buttons        = keys;
        o_result.left_x         = f.b7;
        o_result.left_y         = ~f.b8;
        o_result.right_x        = f.b5;
        o_result.right_y        = f.b6;
        o_result.left_trigger   = keys[i_cfg.left_trigger_bit] ? 8'hFF : 8'h00;
        o_result.right_trigger  = keys[i_cfg.right_trigger_bit] ? 8'hFF : 8'h00;
        o_result.reinit_request = reinit;
        o_result.frame_replaced = empty;
        o_result.link_lost      = lost;
    end

endmodule

`default_nettype wire
